FILE: src/btl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap text layout block.
// No dependencies; imported by btl_glyph_store, bitmap_text_layout_top and the testbench.
package btl_pkg;

    // Request kinds carried by the action field
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_START = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SPACE_ADVANCE = 3'd2,
        CFG_LINE_ADVANCE  = 3'd3,
        CFG_CELL_WIDTH    = 3'd4,
        CFG_CELL_HEIGHT   = 3'd5,
        CFG_WRAP_COUNT    = 3'd6
    } t_cfg_idx;

    // Character codes with special handling
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    // One glyph entry, low byte is the x offset
    typedef struct packed {
        logic [7:0] h;
        logic [7:0] w;
        logic [7:0] y;
        logic [7:0] x;
    } t_glyph;

    // Control strobes from the request stage to the glyph store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_gs_req;

endpackage

FILE: src/bitmap_text_layout_top.sv
`timescale 1ns / 1ps
// Top level of the bitmap text layout block: request stage, cursor logic, result register.
// Depends on btl_pkg and btl_glyph_store.

// Takes one request per clock unless the result register blocks: a request is
// accepted into a one-deep stage while the glyph store is read, the cursor and
// the rectangles are worked out from that stage, and a drawn glyph is loaded
// into the result register as the stage moves on. Load, start, space, newline,
// tab and unused requests give no result. The input side only stalls when the
// result register is full and not taken. The user must write configuration
// through the plain write strobe only while idle; the block never checks it.
module bitmap_text_layout_top
    import btl_pkg::*;
#(
    parameter int GLYPH_COUNT   = 256,
    parameter int CELLS_PER_ROW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // requests
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_glyph_x,
    input  logic [7:0]         i_glyph_y,
    input  logic [7:0]         i_glyph_w,
    input  logic [7:0]         i_glyph_h,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_src_x,
    output logic [11:0]        o_src_y,
    output logic [7:0]         o_rect_w,
    output logic [7:0]         o_rect_h,
    output logic signed [15:0] o_dst_x,
    output logic signed [15:0] o_dst_y
);

    localparam int AW = $clog2(GLYPH_COUNT);

    // Row and column of each code in the sheet, built at elaboration
    function automatic logic [255:0][7:0] f_row_tab();
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'(i / CELLS_PER_ROW);
        end
        return t;
    endfunction

    function automatic logic [255:0][7:0] f_col_tab();
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'(i % CELLS_PER_ROW);
        end
        return t;
    endfunction

    localparam logic [255:0][7:0] ROW_TAB = f_row_tab();
    localparam logic [255:0][7:0] COL_TAB = f_col_tab();

    // Configuration registers
    logic [15:0] r_origin_x, r_origin_y, r_line_advance;
    logic [7:0]  r_space_advance, r_cell_width, r_cell_height, r_wrap_count;

    // Cursor state
    logic [15:0] r_cursor_x, r_cursor_y;
    logic [7:0]  r_line_count;
    logic [15:0] n_cursor_x, n_cursor_y;
    logic [7:0]  n_line_count;

    // Request stage
    logic        r_s1_valid;
    t_action     r_s1_action;
    logic [7:0]  r_s1_code;
    logic        r_s1_in_range;
    logic [7:0]  r_s1_row, r_s1_col;

    // Result register
    logic        r_out_valid;
    logic [11:0] r_src_x, r_src_y;
    logic [7:0]  r_rect_w, r_rect_h;
    logic [15:0] r_dst_x, r_dst_y;

    logic        in_accept;
    logic        in_range;
    logic        s1_fire;
    logic        s1_emit;
    t_gs_req     gs_req;
    t_glyph      gs_wr_data;
    t_glyph      gs_rd_data;
    t_glyph      glyph;

    // Handshake
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_char_code} < 9'(GLYPH_COUNT);

    // Glyph store: write on load, read for every request in range
    assign gs_req.wr_en = in_accept && (t_action'(i_action) == ACT_LOAD) && in_range;
    assign gs_req.rd_en = in_accept && in_range;
    assign gs_wr_data   = '{h: i_glyph_h, w: i_glyph_w, y: i_glyph_y, x: i_glyph_x};

    btl_glyph_store #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_glyph_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (gs_req),
        .i_addr    (i_char_code[AW-1:0]),
        .i_wr_data (gs_wr_data),
        .o_rd_data (gs_rd_data)
    );

    assign glyph = r_s1_in_range ? gs_rd_data : '0;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_space_advance <= '0;
            r_line_advance  <= '0;
            r_cell_width    <= '0;
            r_cell_height   <= '0;
            r_wrap_count    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data;
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data;
                CFG_SPACE_ADVANCE: r_space_advance <= i_cfg_data[7:0];
                CFG_LINE_ADVANCE:  r_line_advance  <= i_cfg_data;
                CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data[7:0];
                CFG_CELL_HEIGHT:   r_cell_height   <= i_cfg_data[7:0];
                CFG_WRAP_COUNT:    r_wrap_count    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted request and its sheet position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action   <= t_action'(i_action);
            r_s1_code     <= i_char_code;
            r_s1_in_range <= in_range;
            r_s1_row      <= ROW_TAB[i_char_code];
            r_s1_col      <= COL_TAB[i_char_code];
        end
    end

    // Advance the cursor
    always_comb begin
        logic [15:0] x1, y1;
        logic [7:0]  cnt_base, cnt_inc;
        logic        brk;
        n_cursor_x   = r_cursor_x;
        n_cursor_y   = r_cursor_y;
        n_line_count = r_line_count;
        s1_emit      = 1'b0;
        x1           = r_cursor_x;
        y1           = r_cursor_y;
        cnt_base     = r_line_count;
        cnt_inc      = '0;
        brk          = 1'b0;
        case (r_s1_action)
            ACT_START: begin
                n_cursor_x   = r_origin_x;
                n_cursor_y   = r_origin_y;
                n_line_count = '0;
            end
            ACT_CHAR: begin
                if (r_s1_code == CODE_SPACE) begin
                    x1 = r_cursor_x + {8'd0, r_space_advance};
                end else if (r_s1_code == CODE_NEWLINE) begin
                    x1       = r_origin_x;
                    y1       = r_cursor_y + r_line_advance;
                    cnt_base = '0;
                end else if (r_s1_code == CODE_TAB) begin
                    x1 = r_cursor_x + {r_line_advance[13:0], 2'b00};
                end else begin
                    x1      = r_cursor_x + {8'd0, glyph.w} + 16'd1;
                    s1_emit = 1'b1;
                end
                // Forced break once the line is full
                cnt_inc = cnt_base + 8'd1;
                brk     = (r_wrap_count != 8'd0) && (cnt_inc == r_wrap_count);
                if (r_wrap_count == 8'd0) begin
                    n_line_count = cnt_base;
                    n_cursor_x   = x1;
                    n_cursor_y   = y1;
                end else if (brk) begin
                    n_line_count = '0;
                    n_cursor_x   = r_origin_x;
                    n_cursor_y   = y1 + r_line_advance;
                end else begin
                    n_line_count = cnt_inc;
                    n_cursor_x   = x1;
                    n_cursor_y   = y1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x   <= '0;
            r_cursor_y   <= '0;
            r_line_count <= '0;
        end else if (s1_fire) begin
            r_cursor_x   <= n_cursor_x;
            r_cursor_y   <= n_cursor_y;
            r_line_count <= n_line_count;
        end
    end

    // Result register: load on a drawn glyph, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] sx, sy;
        sx = {8'd0, glyph.x} + r_s1_col * r_cell_width;
        sy = {8'd0, glyph.y} + r_s1_row * r_cell_height;
        if (s1_fire && s1_emit) begin
            r_src_x  <= sx[11:0];
            r_src_y  <= sy[11:0];
            r_rect_w <= glyph.w;
            r_rect_h <= glyph.h;
            r_dst_x  <= r_cursor_x;
            r_dst_y  <= r_cursor_y + {8'd0, glyph.y};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_src_x     = r_src_x;
    assign o_src_y     = r_src_y;
    assign o_rect_w    = r_rect_w;
    assign o_rect_h    = r_rect_h;
    assign o_dst_x     = r_dst_x;
    assign o_dst_y     = r_dst_y;

    // Input stalls only behind a full, untaken result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    // A request that draws nothing never raises a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !s1_emit && (!r_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("result raised by a request that draws nothing");

    // Start puts the cursor at the origin with an empty line
    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_action == ACT_START)
        |=> (r_cursor_x == $past(r_origin_x) && r_cursor_y == $past(r_origin_y)
             && r_line_count == 8'd0))
        else $error("start did not return cursor to origin");

    // The line count never rests on the wrap limit after a character
    a_wrap_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_action == ACT_CHAR && r_wrap_count != 8'd0 && !i_cfg_we)
        |=> (r_line_count != r_wrap_count))
        else $error("line count reached wrap limit without a break");

endmodule

FILE: src/btl_glyph_store.sv
`timescale 1ns / 1ps
// Glyph entry memory with per-entry valid bits; unwritten entries read as zero.
// Depends on btl_pkg for t_glyph and t_gs_req.
module btl_glyph_store
    import btl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256,
    parameter int AW          = $clog2(GLYPH_COUNT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_gs_req       i_req,
    input  logic [AW-1:0] i_addr,
    input  t_glyph        i_wr_data,
    output t_glyph        o_rd_data
);

    t_glyph               mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] r_valid;
    t_glyph               r_rd_data;
    logic                 r_rd_valid;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
    end

    // Mark written entries; reset clears every mark at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: tb/tb_bitmap_text_layout_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_text_layout_top: sends glyph loads, string starts and
// characters, predicts each drawn rectangle and compares it with the result channel.
// Depends on btl_pkg and bitmap_text_layout_top.
module tb_bitmap_text_layout_top;
    import btl_pkg::*;

    localparam int GLYPH_COUNT   = 256;
    localparam int CELLS_PER_ROW = 16;
    localparam int DRAIN_CYCLES  = 4;
    localparam int STALL_LIMIT   = 2000;

    // Register settings used per phase
    typedef enum int {
        SET_LOWEST,
        SET_HIGHEST,
        SET_SCATTER,
        SET_TYPICAL
    } t_setting;

    // One drawn glyph as it leaves the block
    typedef struct packed {
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [7:0]  rect_w;
        logic [7:0]  rect_h;
        logic [15:0] dst_x;
        logic [15:0] dst_y;
    } t_draw;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_action;
    logic [7:0]         i_char_code;
    logic [7:0]         i_glyph_x;
    logic [7:0]         i_glyph_y;
    logic [7:0]         i_glyph_w;
    logic [7:0]         i_glyph_h;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [11:0]        o_src_x;
    logic [11:0]        o_src_y;
    logic [7:0]         o_rect_w;
    logic [7:0]         o_rect_h;
    logic signed [15:0] o_dst_x;
    logic signed [15:0] o_dst_y;

    // Mirrored registers and layout state
    logic [15:0] org_x, org_y, line_adv;
    logic [7:0]  space_adv, cell_w, cell_h, wrap_at;
    logic [15:0] pen_x, pen_y;
    logic [7:0]  line_chars;
    t_glyph      glyphs [GLYPH_COUNT];

    t_draw pending_draws [$];
    int    fail_count       = 0;
    int    quiet_cycles     = 0;
    int    sink_hold_cycles = 0;
    bit    src_steady       = 1'b0;
    bit    sink_steady      = 1'b0;

    bitmap_text_layout_top #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .CELLS_PER_ROW (CELLS_PER_ROW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_glyph_x   (i_glyph_x),
        .i_glyph_y   (i_glyph_y),
        .i_glyph_w   (i_glyph_w),
        .i_glyph_h   (i_glyph_h),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_src_x     (o_src_x),
        .o_src_y     (o_src_y),
        .o_rect_w    (o_rect_w),
        .o_rect_h    (o_rect_h),
        .o_dst_x     (o_dst_x),
        .o_dst_y     (o_dst_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic clear_layout_state();
        org_x      = '0;
        org_y      = '0;
        line_adv   = '0;
        space_adv  = '0;
        cell_w     = '0;
        cell_h     = '0;
        wrap_at    = '0;
        pen_x      = '0;
        pen_y      = '0;
        line_chars = '0;
        foreach (glyphs[k]) glyphs[k] = '0;
    endtask

    task automatic apply_register(t_cfg_idx idx, logic [15:0] value);
        case (idx)
            CFG_ORIGIN_X:      org_x     = value;
            CFG_ORIGIN_Y:      org_y     = value;
            CFG_SPACE_ADVANCE: space_adv = value[7:0];
            CFG_LINE_ADVANCE:  line_adv  = value;
            CFG_CELL_WIDTH:    cell_w    = value[7:0];
            CFG_CELL_HEIGHT:   cell_h    = value[7:0];
            CFG_WRAP_COUNT:    wrap_at   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic break_line();
        pen_y      = pen_y + line_adv;
        pen_x      = org_x;
        line_chars = '0;
    endtask

    // Work out the effect of one accepted request; queue a draw where one results
    task automatic lay_out_request(t_action act, logic [7:0] code,
                                   logic [7:0] gx, logic [7:0] gy,
                                   logic [7:0] gw, logic [7:0] gh);
        t_glyph g;
        t_draw  d;
        int     col;
        int     row;
        case (act)
            ACT_LOAD: begin
                if (code < GLYPH_COUNT) glyphs[code] = {gh, gw, gy, gx};
            end
            ACT_START: begin
                pen_x      = org_x;
                pen_y      = org_y;
                line_chars = '0;
            end
            ACT_CHAR: begin
                if (code == CODE_SPACE) begin
                    pen_x = pen_x + {8'd0, space_adv};
                end else if (code == CODE_NEWLINE) begin
                    break_line();
                end else if (code == CODE_TAB) begin
                    pen_x = pen_x + (line_adv << 2);
                end else begin
                    g        = (code < GLYPH_COUNT) ? glyphs[code] : '0;
                    col      = int'(code) % CELLS_PER_ROW;
                    row      = int'(code) / CELLS_PER_ROW;
                    d.src_x  = 12'(int'(g.x) + col * int'(cell_w));
                    d.src_y  = 12'(int'(g.y) + row * int'(cell_h));
                    d.rect_w = g.w;
                    d.rect_h = g.h;
                    d.dst_x  = pen_x;
                    d.dst_y  = pen_y + {8'd0, g.y};
                    pending_draws.push_back(d);
                    pen_x = pen_x + {8'd0, g.w} + 16'd1;
                end
                // forced break once the line holds wrap_at characters
                if (wrap_at != 8'd0) begin
                    line_chars = line_chars + 8'd1;
                    if (line_chars == wrap_at) break_line();
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Track register writes and requests, and check every accepted draw
    always @(posedge i_clk) begin
        t_draw got;
        t_draw want;
        if (i_rst_n) begin
            if (i_cfg_we) apply_register(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_in_valid && o_in_ready)
                lay_out_request(t_action'(i_action), i_char_code,
                                i_glyph_x, i_glyph_y, i_glyph_w, i_glyph_h);
            if (o_out_valid && i_out_ready) begin
                got = {o_src_x, o_src_y, o_rect_w, o_rect_h, o_dst_x, o_dst_y};
                if (pending_draws.size() == 0) begin
                    $display("%0t: unexpected draw, expected none, actual 0x%0h", $time, got);
                    fail_count++;
                end else begin
                    want = pending_draws.pop_front();
                    compare_field("src_x",  want.src_x,  got.src_x);
                    compare_field("src_y",  want.src_y,  got.src_y);
                    compare_field("rect_w", want.rect_w, got.rect_w);
                    compare_field("rect_h", want.rect_h, got.rect_h);
                    compare_field("dst_x",  want.dst_x,  got.dst_x);
                    compare_field("dst_y",  want.dst_y,  got.dst_y);
                end
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[bitmap_text_layout_top] ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, steady stretches and long hold-offs
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                sink_hold_cycles--;
            end else if (sink_steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request, with an occasional gap, and hold it until accepted
    task automatic send_request(t_action act, logic [7:0] code,
                                logic [7:0] gx, logic [7:0] gy,
                                logic [7:0] gw, logic [7:0] gh);
        if (!src_steady && $urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 2)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_char_code <= code;
        i_glyph_x   <= gx;
        i_glyph_y   <= gy;
        i_glyph_w   <= gw;
        i_glyph_h   <= gh;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_char(logic [7:0] code);
        send_request(ACT_CHAR, code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stop offering, let every draw come out, then allow the pipeline to empty
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_register(t_cfg_idx idx, t_setting setting);
        bit is_signed;
        is_signed = (idx == CFG_ORIGIN_X) || (idx == CFG_ORIGIN_Y) || (idx == CFG_LINE_ADVANCE);
        case (setting)
            SET_LOWEST:  return is_signed ? 16'h8000 : 16'h0000;
            SET_HIGHEST: return is_signed ? 16'h7FFF : 16'h00FF;
            SET_SCATTER: return (idx == CFG_WRAP_COUNT) ? 16'($urandom_range(0, 16))
                                                        : 16'($urandom);
            default: begin
                case (idx)
                    CFG_SPACE_ADVANCE: return 16'($urandom_range(1, 8));
                    CFG_LINE_ADVANCE:  return 16'($urandom_range(0, 40) - 20);
                    CFG_CELL_WIDTH,
                    CFG_CELL_HEIGHT:   return 16'($urandom_range(8, 16));
                    CFG_WRAP_COUNT:    return 16'($urandom_range(4, 20));
                    default:           return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic configure(t_setting setting);
        wait_drained();
        for (int i = 0; i <= int'(CFG_WRAP_COUNT); i++)
            write_register(t_cfg_idx'(i), pick_register(t_cfg_idx'(i), setting));
    endtask

    // Mostly characters, with loads, restarts and unused requests mixed in
    task automatic send_random_request();
        int         r;
        int         s;
        logic [7:0] code;
        r    = $urandom_range(99);
        s    = $urandom_range(99);
        code = 8'($urandom);
        if (r < 8) begin
            send_request(ACT_LOAD, code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (r < 11) begin
            send_request(ACT_START, code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (r < 13) begin
            send_request(ACT_NONE, code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            if (s < 6)       code = CODE_SPACE;
            else if (s < 10) code = CODE_NEWLINE;
            else if (s < 14) code = CODE_TAB;
            send_char(code);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Draw with registers and glyph table still at their reset values, before any start
    task automatic test_layout_from_reset();
        send_char(8'd65);
        send_char(8'd66);
        send_char(CODE_SPACE);
        wait_drained();
    endtask

    // Field extremes, every request kind, special characters and a short wrap
    task automatic test_directed_strings();
        write_register(CFG_ORIGIN_X,      16'h7FFF);
        write_register(CFG_ORIGIN_Y,      16'h8000);
        write_register(CFG_SPACE_ADVANCE, 16'h00FF);
        write_register(CFG_LINE_ADVANCE,  16'hFFF0);
        write_register(CFG_CELL_WIDTH,    16'h00FF);
        write_register(CFG_CELL_HEIGHT,   16'h00FF);
        write_register(CFG_WRAP_COUNT,    16'h0000);
        send_request(ACT_LOAD, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(ACT_LOAD, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ACT_LOAD, 8'd65,  8'hAA, 8'h55, 8'h0F, 8'hF0);
        send_request(ACT_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_char(8'd65);
        send_char(8'd255);
        send_char(8'd0);
        send_char(CODE_SPACE);
        send_char(CODE_TAB);
        send_char(8'd65);
        send_char(CODE_NEWLINE);
        send_request(ACT_NONE, 8'd65, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_char(8'd65);
        wait_drained();
        write_register(CFG_WRAP_COUNT, 16'h0002);
        send_request(ACT_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_char(8'd65);
        send_char(8'd65);
        send_char(8'd65);
        send_char(CODE_NEWLINE);
        send_char(8'd65);
        send_char(8'd255);
        wait_drained();
    endtask

    // Lower the wrap count below the current line count: the break only comes
    // after the 8-bit count has wrapped round
    task automatic test_count_wraps_past_limit();
        logic [7:0] code;
        configure(SET_TYPICAL);
        write_register(CFG_WRAP_COUNT, 16'h0003);
        send_request(ACT_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_char(8'd65);
        send_char(8'd66);
        wait_drained();
        write_register(CFG_WRAP_COUNT, 16'h0001);
        repeat (256) begin
            code = 8'($urandom);
            if (code == CODE_NEWLINE) code = 8'd65;
            send_char(code);
        end
        wait_drained();
    endtask

    // Hold the result side off so the block fills and stalls its input
    task automatic test_result_backpressure();
        configure(SET_TYPICAL);
        src_steady       = 1'b1;
        sink_hold_cycles = 80;
        send_request(ACT_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (40) send_char(8'($urandom_range(33, 126)));
        src_steady = 1'b0;
        wait_drained();
        repeat (10) send_char(8'($urandom_range(33, 126)));
        wait_drained();
    endtask

    // Random traffic under several register settings; the last phase never idles
    task automatic test_random_phases();
        t_setting plan [5];
        plan = '{SET_LOWEST, SET_HIGHEST, SET_SCATTER, SET_TYPICAL, SET_TYPICAL};
        foreach (plan[p]) begin
            configure(plan[p]);
            src_steady  = (p == 4);
            sink_steady = (p == 4);
            repeat (12)
                send_request(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
            send_request(ACT_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
            repeat (50) send_random_request();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        wait_drained();
    endtask

    // Reset, run each test in turn, report
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_action    = '0;
        i_char_code = '0;
        i_glyph_x   = '0;
        i_glyph_y   = '0;
        i_glyph_w   = '0;
        i_glyph_h   = '0;
        clear_layout_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_layout_from_reset();
        test_directed_strings();
        test_count_wraps_past_limit();
        test_result_backpressure();
        test_random_phases();

        wait_drained();
        if (fail_count == 0) begin
            $display("[bitmap_text_layout_top] OK");
        end else begin
            $display("[bitmap_text_layout_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/btl_pkg.sv
src/btl_glyph_store.sv
src/bitmap_text_layout_top.sv
tb/tb_bitmap_text_layout_top.sv
